// ===== rtl/acd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acd_pkg: shared types and constants
// Widths, status codes, register indexes and the control/status bundles
// that join the chunk dispatcher controller and datapath.
// ----------------------------------------------------------------------------
package acd_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int ITER_BITS   = 16;
  localparam int SET_IDX_W   = $clog2(MAX_WORKERS);
  localparam int WCNT_W      = $clog2(MAX_WORKERS + 1);
  localparam int DIV_CNT_W   = $clog2(ITER_BITS);
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int STATUS_W    = 2;

  typedef logic [ITER_BITS-1:0] iter_t;
  typedef logic [SET_IDX_W-1:0] set_idx_t;
  typedef logic [WCNT_W-1:0]    wcnt_t;
  typedef logic [STATUS_W-1:0]  status_t;

  localparam status_t STATUS_STARTED = 2'd0;
  localparam status_t STATUS_GRANTED = 2'd1;
  localparam status_t STATUS_DONE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ITER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_WORKERS = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // latch worker count, total and worker id
    logic div_go;      // launch the shared divider
    logic div_chunk;   // dividend is the chosen set size, else the total
    logic sweep_init;  // reset layout walk
    logic sweep_wr;    // write one set of the new partition
    logic own_chk;     // look at the requester's own set
    logic scan_step;   // one step of the fullest-set search
    logic upd;         // take the chunk and emit a grant
    logic emit_start;  // emit partition-started result
    logic emit_done;   // emit nothing-left result
  } acd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic own_hit;
    logic idx_last;
    logic div_done;
    logic empty;
  } acd_sts_t;

  // clamp the configured worker count to 1..MAX_WORKERS
  function automatic wcnt_t eff_workers(input wcnt_t n);
    wcnt_t p;
    p = n;
    if (n == '0) begin
      p = wcnt_t'(1);
    end else if (n > wcnt_t'(MAX_WORKERS)) begin
      p = wcnt_t'(MAX_WORKERS);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/affinity_chunk_dispatcher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affinity_chunk_dispatcher_core: affinity-scheduling chunk dispatcher
// Splits a loop's iterations into one set per worker and hands out chunks,
// stealing from the fullest set once a worker's own set runs dry.
// ----------------------------------------------------------------------------
// usage
//   - command channel: a transaction is taken when start is high and busy
//     is low; in_req_type 0 lays out a new partition, 1 asks for a chunk
//     for worker in_worker_id
//   - result channel: out_valid strobes for exactly one cycle with status,
//     chunk bounds and source set; the receiver cannot stall it
//   - cfg port: cfg_we writes cfg_idx 0 (total iterations) or 1 (worker
//     count) at once; write only while busy is low
//   - sequence: a partition runs a divide, then lays out the sixteen sets
//     in turn; a chunk from the worker's own set takes one divide by the
//     worker count; a stolen chunk or a done answer first searches all
//     the sets; one transaction is in flight at a time
//   - busy falls in the cycle the result strobes, so the next command can
//     be taken alongside the result
//   - reset: all sets empty, total 1, one worker; a request answers done
// ----------------------------------------------------------------------------
module affinity_chunk_dispatcher_core
  import acd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_req_type,
  input  wire set_idx_t              in_worker_id,
  // result channel
  output logic                       out_valid,
  output status_t                    out_status,
  output iter_t                      out_chunk_lower,
  output iter_t                      out_chunk_upper,
  output set_idx_t                   out_source_set,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  acd_cmd_t cmd;
  acd_sts_t sts;

  // sequencer: one transaction at a time
  acd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  // set table, shared divider and result registers
  acd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_worker_id    (in_worker_id),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_chunk_lower (out_chunk_lower),
    .out_chunk_upper (out_chunk_upper),
    .out_source_set  (out_source_set)
  );

  // every transaction ends with exactly one result, as busy drops
  a_result_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // a taken command always occupies the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command taken but sequencer not busy");

  // results never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // start and done results carry no chunk
  a_no_chunk_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_GRANTED) |->
      (out_chunk_lower == '0 && out_chunk_upper == '0 && out_source_set == '0))
    else $error("non-grant result carries chunk fields");

  // a granted chunk is never empty
  a_chunk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_GRANTED) |->
      (out_chunk_upper != out_chunk_lower))
    else $error("granted chunk is empty");

endmodule
`default_nettype wire

// ===== rtl/acd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acd_div: radix-2 restoring divider
// Divides an iteration count by the worker count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module acd_div
  import acd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  go,
  input  wire iter_t dividend,
  input  wire wcnt_t divisor,
  output logic       done,
  output iter_t      quotient,
  output wcnt_t      remainder
);

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  iter_t                q_r;
  wcnt_t                r_r;
  wcnt_t                dvs_r;
  logic [WCNT_W:0]      trial;
  logic                 fits;

  assign trial = {r_r, q_r[ITER_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(ITER_BITS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= dividend;
      r_r   <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      q_r <= {q_r[ITER_BITS-2:0], fits};
      r_r <= fits ? WCNT_W'(trial - {1'b0, dvs_r}) : WCNT_W'(trial);
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;

endmodule
`default_nettype wire

// ===== rtl/acd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acd_datapath: set table, search and chunk arithmetic
// Holds configuration, per-set size and next iteration, the remaining
// total, the fullest-set search registers and the result registers.
// ----------------------------------------------------------------------------
module acd_datapath
  import acd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire set_idx_t              in_worker_id,
  input  wire acd_cmd_t              cmd,
  output acd_sts_t                   sts,
  output logic                       out_valid,
  output status_t                    out_status,
  output iter_t                      out_chunk_lower,
  output iter_t                      out_chunk_upper,
  output set_idx_t                   out_source_set
);

  iter_t    tot_cfg_r;
  wcnt_t    nw_cfg_r;
  wcnt_t    p_r;
  iter_t    n_r;
  set_idx_t wid_r;
  iter_t    rem_r [MAX_WORKERS];
  iter_t    nxt_r [MAX_WORKERS];
  iter_t    tl_r;
  set_idx_t idx_r;
  iter_t    pos_r;
  set_idx_t src_r;
  iter_t    best_r;

  logic     out_valid_r;
  status_t  out_status_r;
  iter_t    out_lower_r;
  iter_t    out_upper_r;
  set_idx_t out_src_r;

  set_idx_t rd_idx;
  iter_t    rd_rem;
  iter_t    rd_next;
  logic     div_done;
  iter_t    div_q;
  wcnt_t    div_r;
  iter_t    sz;
  iter_t    chunk;
  iter_t    upper;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_cfg_r <= iter_t'(1);
      nw_cfg_r  <= wcnt_t'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TOTAL_ITER:  tot_cfg_r <= cfg_wdata[ITER_BITS-1:0];
        REG_NUM_WORKERS: nw_cfg_r  <= cfg_wdata[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // single read index into the set table
  always_comb begin
    priority if (cmd.own_chk) begin
      rd_idx = wid_r;
    end else if (cmd.scan_step) begin
      rd_idx = idx_r;
    end else begin
      rd_idx = src_r;
    end
  end

  assign rd_rem  = rem_r[rd_idx];
  assign rd_next = nxt_r[rd_idx];

  acd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (cmd.div_go),
    .dividend  (cmd.div_chunk ? best_r : n_r),
    .divisor   (p_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // size of the set being laid out: base, plus one for the leading sets
  always_comb begin
    sz = '0;
    if ({1'b0, idx_r} < p_r) begin
      sz = div_q + (({1'b0, idx_r} < div_r) ? iter_t'(1) : iter_t'(0));
    end
  end

  assign chunk = (div_q == '0) ? iter_t'(1) : div_q;
  assign upper = rd_next + chunk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WORKERS; i++) begin
        rem_r[i] <= '0;
        nxt_r[i] <= '0;
      end
      tl_r <= '0;
    end else begin
      if (cmd.sweep_init) begin
        tl_r <= n_r;
      end
      if (cmd.sweep_wr) begin
        rem_r[idx_r] <= sz;
        nxt_r[idx_r] <= pos_r;
      end
      if (cmd.upd) begin
        rem_r[src_r] <= best_r - chunk;
        nxt_r[src_r] <= upper;
        tl_r         <= (tl_r > chunk) ? (tl_r - chunk) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r   <= eff_workers(nw_cfg_r);
      n_r   <= tot_cfg_r;
      wid_r <= in_worker_id;
    end
    if (cmd.sweep_init) begin
      idx_r <= '0;
      pos_r <= '0;
    end else if (cmd.sweep_wr) begin
      idx_r <= idx_r + 1'b1;
      pos_r <= pos_r + sz;
    end else if (cmd.own_chk) begin
      idx_r <= '0;
      if ({1'b0, wid_r} < p_r && rd_rem != '0) begin
        src_r  <= wid_r;
        best_r <= rd_rem;
      end
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r == '0 || rd_rem > best_r) begin
        src_r  <= idx_r;
        best_r <= rd_rem;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_start | cmd.emit_done | cmd.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_status_r <= STATUS_GRANTED;
      out_lower_r  <= rd_next;
      out_upper_r  <= upper;
      out_src_r    <= src_r;
    end else if (cmd.emit_start || cmd.emit_done) begin
      out_status_r <= cmd.emit_start ? STATUS_STARTED : STATUS_DONE;
      out_lower_r  <= '0;
      out_upper_r  <= '0;
      out_src_r    <= '0;
    end
  end

  assign sts.own_hit  = ({1'b0, wid_r} < p_r) && (rd_rem != '0);
  assign sts.idx_last = idx_r == set_idx_t'(MAX_WORKERS - 1);
  assign sts.div_done = div_done;
  assign sts.empty    = (tl_r == '0) || (best_r == '0);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chunk_lower = out_lower_r;
  assign out_chunk_upper = out_upper_r;
  assign out_source_set  = out_src_r;

endmodule
`default_nettype wire

// ===== rtl/acd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acd_ctrl: dispatcher sequencer
// Steps the datapath through partition layout or chunk grant.
// ----------------------------------------------------------------------------
module acd_ctrl
  import acd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_req_type,
  input  wire acd_sts_t sts,
  output acd_cmd_t      cmd,
  output logic          busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SDIV  = 4'd1;
  localparam logic [3:0] S_SWAIT = 4'd2;
  localparam logic [3:0] S_SWEEP = 4'd3;
  localparam logic [3:0] S_OWN   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_CDIV  = 4'd7;
  localparam logic [3:0] S_CWAIT = 4'd8;
  localparam logic [3:0] S_UPD   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = in_req_type ? S_OWN : S_SDIV;
        end
      end
      S_SDIV: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts.div_done) begin
          cmd.sweep_init = 1'b1;
          state_nxt      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_OWN: begin
        cmd.own_chk = 1'b1;
        state_nxt   = sts.own_hit ? S_CDIV : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.empty) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_CDIV;
        end
      end
      S_CDIV: begin
        cmd.div_go    = 1'b1;
        cmd.div_chunk = 1'b1;
        state_nxt     = S_CWAIT;
      end
      S_CWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for the affinity chunk dispatcher
// Drives start and chunk-request commands, keeps a cycle-free model of the
// worker sets and checks every result strobe against it, in order. Runs a
// directed pass over the corner cases, then random phases under several
// config settings and command idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import acd_pkg::*;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_CHUNK = 1'b1;
  localparam int   CLK_HALF  = 6;
  localparam int   MAX_SHOWN = 10;
  localparam int   N_PHASES  = 12;
  localparam int   PHASE_LEN = 50;

  typedef struct packed {
    status_t  status;
    iter_t    lower;
    iter_t    upper;
    set_idx_t src;
  } grant_t;

  // model of the worker sets plus the queue of results still owed
  class chunk_scoreboard;
    iter_t       set_left[MAX_WORKERS];
    iter_t       set_front[MAX_WORKERS];
    iter_t       iters_left;
    iter_t       total_reg;
    logic [4:0]  workers_reg;
    grant_t      owed_q[$];
    int unsigned mismatches;

    function new();
      foreach (set_left[t]) begin
        set_left[t]  = '0;
        set_front[t] = '0;
      end
      iters_left  = '0;
      total_reg   = iter_t'(1);
      workers_reg = 5'd1;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_TOTAL_ITER) begin
        total_reg = data;
      end else begin
        workers_reg = data[4:0];
      end
    endfunction

    // worker count as the block uses it: zero means one, clamp at the max
    function int unsigned worker_count();
      if (workers_reg == 0) return 1;
      if (workers_reg > MAX_WORKERS) return MAX_WORKERS;
      return workers_reg;
    endfunction

    function void note_command(logic req_type, set_idx_t wid);
      grant_t      g;
      int unsigned p, base, extra, pos, sz, chunk, src;
      bit          own;
      p = worker_count();
      g = '0;
      if (req_type == CMD_START) begin
        base  = total_reg / p;
        extra = total_reg % p;
        pos   = 0;
        for (int t = 0; t < MAX_WORKERS; t++) begin
          sz = 0;
          if (t < p) sz = base + ((t < extra) ? 1 : 0);
          set_left[t]  = iter_t'(sz);
          set_front[t] = iter_t'(pos);
          pos          = (pos + sz) & 32'hFFFF;
        end
        iters_left = total_reg;
        g.status   = STATUS_STARTED;
      end else begin
        own = (wid < p) && (set_left[wid] != 0);
        src = wid;
        if (!own) begin
          // fullest set over all sixteen, lowest index on a tie
          src = 0;
          for (int t = 1; t < MAX_WORKERS; t++) begin
            if (set_left[t] > set_left[src]) src = t;
          end
        end
        if (!own && (iters_left == 0 || set_left[src] == 0)) begin
          g.status = STATUS_DONE;
        end else begin
          chunk = set_left[src] / p;
          if (chunk == 0) chunk = 1;
          g.status       = STATUS_GRANTED;
          g.lower        = set_front[src];
          g.upper        = iter_t'(set_front[src] + chunk);
          g.src          = set_idx_t'(src);
          set_front[src] = g.upper;
          set_left[src]  = iter_t'(set_left[src] - chunk);
          iters_left     = (iters_left > chunk) ? iter_t'(iters_left - chunk) : '0;
        end
      end
      owed_q.push_back(g);
    endfunction

    function void check_result(grant_t got);
      grant_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: result with none owed: status %0d lower %0d upper %0d set %0d",
                   $realtime, got.status, got.lower, got.upper, got.src);
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status || got.lower !== want.lower ||
          got.upper !== want.upper || got.src !== want.src) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $write("%0t: mismatch: expected status %0d lower %0d upper %0d set %0d,",
                 $realtime, want.status, want.lower, want.upper, want.src);
          $display(" got status %0d lower %0d upper %0d set %0d",
                   got.status, got.lower, got.upper, got.src);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_req_type;
  set_idx_t              in_worker_id;
  logic                  out_valid;
  status_t               out_status;
  iter_t                 out_chunk_lower;
  iter_t                 out_chunk_upper;
  set_idx_t              out_source_set;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  chunk_scoreboard sb;
  int unsigned     idle_pct;

  affinity_chunk_dispatcher_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_worker_id    (in_worker_id),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_chunk_lower (out_chunk_lower),
    .out_chunk_upper (out_chunk_upper),
    .out_source_set  (out_source_set),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // result strobe lasts one cycle and cannot be held off
  always @(posedge clk) begin
    grant_t got;
    if (rst_n && out_valid) begin
      got.status = out_status;
      got.lower  = out_chunk_lower;
      got.upper  = out_chunk_upper;
      got.src    = out_source_set;
      sb.check_result(got);
    end
  end

  // one command transaction; start stays high when the next one follows at once
  task automatic send_cmd(logic req_type, set_idx_t wid);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start        <= 1'b1;
    in_req_type  <= req_type;
    in_worker_id <= wid;
    do @(posedge clk); while (busy);
    sb.note_command(req_type, wid);
  endtask

  // every command owes exactly one result, so an empty queue means idle
  task automatic settle();
    start <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_cfg(logic [15:0] total, logic [4:0] workers);
    settle();
    if ($urandom_range(0, 1) == 1) begin
      write_cfg(REG_TOTAL_ITER, total);
      write_cfg(REG_NUM_WORKERS, CFG_DATA_W'(workers));
    end else begin
      write_cfg(REG_NUM_WORKERS, CFG_DATA_W'(workers));
      write_cfg(REG_TOTAL_ITER, total);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] total;
    logic [4:0]  workers;
    int unsigned pick;
    int unsigned waited;
    sb           = new();
    idle_pct     = 0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_req_type  <= CMD_START;
    in_worker_id <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_TOTAL_ITER;
    cfg_wdata    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // requests before any partition answer done
    send_cmd(CMD_CHUNK, 4'd0);
    send_cmd(CMD_CHUNK, 4'd15);
    // reset config: one iteration, one worker
    send_cmd(CMD_START, 4'd0);
    send_cmd(CMD_CHUNK, 4'd0);
    send_cmd(CMD_CHUNK, 4'd0);

    // largest total over the full worker count; start ignores the id
    program_cfg(16'hFFFF, 5'd16);
    send_cmd(CMD_START, 4'd15);
    send_cmd(CMD_CHUNK, 4'd0);
    send_cmd(CMD_CHUNK, 4'd15);
    send_cmd(CMD_CHUNK, 4'd9);

    // worker count zero after the start: divisor becomes one
    program_cfg(16'hFFFF, 5'd0);
    send_cmd(CMD_CHUNK, 4'd3);
    send_cmd(CMD_CHUNK, 4'd3);

    // count above the max saturates; empty total leaves nothing to hand out
    program_cfg(16'd0, 5'd31);
    send_cmd(CMD_START, 4'd0);
    send_cmd(CMD_CHUNK, 4'd2);

    // small split with uneven sets, ids past the count and stealing to done
    program_cfg(16'd5, 5'd4);
    send_cmd(CMD_START, 4'd0);
    send_cmd(CMD_CHUNK, 4'd9);
    send_cmd(CMD_CHUNK, 4'd0);
    send_cmd(CMD_CHUNK, 4'd1);
    send_cmd(CMD_CHUNK, 4'd1);
    send_cmd(CMD_CHUNK, 4'd5);
    send_cmd(CMD_CHUNK, 4'd3);

    // sets laid out for sixteen workers, then served under two
    program_cfg(16'd40, 5'd16);
    send_cmd(CMD_START, 4'd0);
    program_cfg(16'd40, 5'd2);
    send_cmd(CMD_CHUNK, 4'd12);
    send_cmd(CMD_CHUNK, 4'd1);
    send_cmd(CMD_CHUNK, 4'd0);

    // random phases: mostly small totals so sets run dry and stealing kicks in
    for (int ph = 0; ph < N_PHASES; ph++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      total = 16'($urandom_range(1, 64));
      else if (pick < 80) total = 16'($urandom_range(65, 1000));
      else if (pick < 93) total = 16'($urandom_range(1001, 65535));
      else if (pick < 97) total = 16'hFFFF;
      else                total = 16'd0;
      if ($urandom_range(0, 99) < 80) workers = 5'($urandom_range(1, 16));
      else                            workers = 5'($urandom_range(0, 31));
      program_cfg(total, workers);

      case (ph % 4)
        1:       idle_pct = 70;
        3:       idle_pct = 36;
        default: idle_pct = 0;
      endcase

      // now and then keep the old partition under the new worker count
      if (ph == 0 || $urandom_range(0, 3) != 0)
        send_cmd(CMD_START, set_idx_t'($urandom_range(0, 15)));
      for (int k = 0; k < PHASE_LEN; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          send_cmd(CMD_START, set_idx_t'($urandom_range(0, 15)));
        else if (pick < 68)
          send_cmd(CMD_CHUNK, set_idx_t'($urandom_range(0, sb.worker_count() - 1)));
        else
          send_cmd(CMD_CHUNK, set_idx_t'($urandom_range(0, 15)));
      end
    end

    start  <= 1'b0;
    waited = 0;
    while (sb.owed_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (sb.owed_q.size() != 0) begin
      sb.mismatches++;
      $display("%0t: %0d results never arrived", $realtime, sb.owed_q.size());
    end
    if (sb.mismatches == 0) begin
      $display("affinity_chunk_dispatcher_core regression: pass");
    end else begin
      $display("affinity_chunk_dispatcher_core regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #8ms;
    $display("affinity_chunk_dispatcher_core regression: fail");
    $finish;
  end

endmodule
